// ===== src/tpq_pkg.sv =====
// shared types, codes and helpers of the timer priority queue
package tpq_pkg;

  localparam logic [1:0] ACT_SCHED   = 2'd0;
  localparam logic [1:0] ACT_CANCEL  = 2'd1;
  localparam logic [1:0] ACT_PROCESS = 2'd2;

  localparam logic [2:0] KIND_GRANT  = 3'd0;
  localparam logic [2:0] KIND_CANCEL = 3'd1;
  localparam logic [2:0] KIND_FIRE   = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_FULL   = 3'd4;

  typedef struct packed {
    logic [31:0] fire;
    logic [31:0] ival;
    logic [31:0] id;
    logic        canc;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [31:0] handle;
    logic        found;
    logic [5:0]  fired_count;
    logic        more_pending;
    logic [4:0]  occupancy;
    logic [31:0] next_delay;
    logic        last;
  } emit_t;

  function automatic logic entry_before(entry_t a, entry_t b);
    logic r;
    if (a.fire != b.fire) r = a.fire < b.fire;
    else r = a.id < b.id;
    return r;
  endfunction

endpackage

// ===== src/tpq_if.sv =====
// request and result channel interfaces

interface tpq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] time_value;
  logic [31:0] repeat_interval;
  logic [31:0] timer_id;
  modport source (output valid, action, time_value, repeat_interval, timer_id, input ready);
  modport sink (input valid, action, time_value, repeat_interval, timer_id, output ready);
endinterface

interface tpq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] handle;
  logic        found;
  logic [5:0]  fired_count;
  logic        more_pending;
  logic [4:0]  occupancy;
  logic [31:0] next_delay;
  logic        last;
  modport source (output valid, kind, handle, found, fired_count, more_pending, occupancy,
                  next_delay, last, input ready);
  modport sink (input valid, kind, handle, found, fired_count, more_pending, occupancy,
                next_delay, last, output ready);
endinterface

// ===== src/timer_priority_queue_top.sv =====
// timer priority queue top level with result register
// schedule: one ram read per heap level on sift-up
// cancel: scans the entries in ram order, then pops cancelled entries off the top
// process: fires or drops due entries from the top, restoring the heap by sift-down
// one request at a time; the result register frees the sequencer while a result waits
// reset clears occupancy and the handle counter; the entry ram is not cleared
module timer_priority_queue_top #(
  parameter int CAPACITY  = 16,
  parameter int MAX_FIRES = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  tpq_in_if.sink     in_ch,
  tpq_out_if.source  out_ch
);

  tpq_pkg::emit_t emit;
  tpq_pkg::emit_t out_r;
  logic           slot_free;

  assign slot_free = !out_r.valid || out_ch.ready;

  tpq_core #(.CAPACITY(CAPACITY), .MAX_FIRES(MAX_FIRES)) u_core (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .emit(emit), .slot_free(slot_free)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (slot_free) begin
      out_r.valid <= emit.valid;
    end
    if (slot_free && emit.valid) begin
      out_r.kind         <= emit.kind;
      out_r.handle       <= emit.handle;
      out_r.found        <= emit.found;
      out_r.fired_count  <= emit.fired_count;
      out_r.more_pending <= emit.more_pending;
      out_r.occupancy    <= emit.occupancy;
      out_r.next_delay   <= emit.next_delay;
      out_r.last         <= emit.last;
    end
  end

  assign out_ch.valid        = out_r.valid;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.handle       = out_r.handle;
  assign out_ch.found        = out_r.found;
  assign out_ch.fired_count  = out_r.fired_count;
  assign out_ch.more_pending = out_r.more_pending;
  assign out_ch.occupancy    = out_r.occupancy;
  assign out_ch.next_delay   = out_r.next_delay;
  assign out_ch.last         = out_r.last;

endmodule

// ===== src/tpq_ram.sv =====
// generic single-port-write ram with registered read
module tpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tpq_core.sv =====
// heap sequencer: schedule, cancel and process over the entry ram
module tpq_core #(
  parameter int CAPACITY  = 16,
  parameter int MAX_FIRES = 63
) (
  input  logic          clk,
  input  logic          rst_n,
  tpq_in_if.sink        in_ch,
  output tpq_pkg::emit_t emit,
  input  logic          slot_free
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SU     = 13'b0000000000010,
    S_SU_CMP = 13'b0000000000100,
    S_SD     = 13'b0000000001000,
    S_SD_R   = 13'b0000000010000,
    S_SD_CMP = 13'b0000000100000,
    S_POP    = 13'b0000001000000,
    S_POP_W  = 13'b0000010000000,
    S_CN_RD  = 13'b0000100000000,
    S_CN_CHK = 13'b0001000000000,
    S_CN_POP = 13'b0010000000000,
    S_PR_CHK = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [31:0]     tv_r, tv_nxt;
  logic [31:0]     tid_r, tid_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [31:0]     hnd_r, hnd_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  tpq_pkg::entry_t cur_r, cur_nxt;
  tpq_pkg::entry_t lch_r, lch_nxt;
  logic            rv_r, rv_nxt;
  logic [5:0]      fires_r, fires_nxt;
  logic            more_r, more_nxt;
  logic            pend_r, pend_nxt;
  logic [2:0]      ekind_r, ekind_nxt;
  logic [31:0]     ehandle_r, ehandle_nxt;
  logic            efound_r, efound_nxt;
  tpq_pkg::entry_t top_r;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  tpq_pkg::entry_t      wdata, rd;
  logic [tpq_pkg::EntryW-1:0] rdata;

  logic [CW:0]   lidx, ridx;
  logic [AW-1:0] pidx;
  logic [CW-1:0] idx_inc;
  logic [32:0]   sat_sum;
  logic          take_l, take_r;
  state_t        sd_done;

  tpq_ram #(.WIDTH(tpq_pkg::EntryW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rd      = tpq_pkg::entry_t'(rdata);
  assign lidx    = {(CW + 1 - AW)'(0), idx_r} + {(CW + 1 - AW)'(0), idx_r} + (CW + 1)'(1);
  assign ridx    = lidx + (CW + 1)'(1);
  assign pidx    = (idx_r - AW'(1)) >> 1;
  assign idx_inc = CW'(idx_r) + CW'(1);
  assign sat_sum = {1'b0, top_r.fire} + {1'b0, top_r.ival};
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    take_l = tpq_pkg::entry_before(lch_r, cur_r);
    take_r = rv_r && tpq_pkg::entry_before(rd, take_l ? lch_r : cur_r);
  end

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; tv_nxt = tv_r; tid_nxt = tid_r;
    cnt_nxt = cnt_r; hnd_nxt = hnd_r; idx_nxt = idx_r; cur_nxt = cur_r;
    lch_nxt = lch_r; rv_nxt = rv_r; fires_nxt = fires_r; more_nxt = more_r;
    pend_nxt = pend_r; ekind_nxt = ekind_r; ehandle_nxt = ehandle_r;
    efound_nxt = efound_r;
    we = 1'b0; waddr = idx_r; wdata = cur_r; raddr = idx_r;
    if (op_r == tpq_pkg::ACT_CANCEL) sd_done = S_CN_POP;
    else if (pend_r) sd_done = S_EMIT;
    else sd_done = S_PR_CHK;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt = in_ch.action; tv_nxt = in_ch.time_value; tid_nxt = in_ch.timer_id;
          efound_nxt = 1'b0; fires_nxt = '0; more_nxt = 1'b0; pend_nxt = 1'b0;
          ehandle_nxt = '0; idx_nxt = '0;
          case (in_ch.action)
            tpq_pkg::ACT_SCHED: begin
              if (cnt_r >= CW'(CAPACITY)) begin
                ekind_nxt = tpq_pkg::KIND_FULL; state_nxt = S_EMIT;
              end else begin
                cur_nxt = '{fire: in_ch.time_value, ival: in_ch.repeat_interval,
                            id: hnd_r, canc: 1'b0};
                ehandle_nxt = hnd_r; hnd_nxt = hnd_r + 32'd1;
                idx_nxt = cnt_r[AW-1:0]; cnt_nxt = cnt_r + CW'(1);
                ekind_nxt = tpq_pkg::KIND_GRANT; state_nxt = S_SU;
              end
            end
            tpq_pkg::ACT_CANCEL: begin
              ekind_nxt = tpq_pkg::KIND_CANCEL;
              state_nxt = (cnt_r == '0) ? S_EMIT : S_CN_RD;
            end
            tpq_pkg::ACT_PROCESS: state_nxt = S_PR_CHK;
            default: begin
              ekind_nxt = tpq_pkg::KIND_DONE; state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_SU: begin
        if (idx_r == '0) begin
          we = 1'b1; state_nxt = S_EMIT;
        end else begin
          raddr = pidx; state_nxt = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        we = 1'b1;
        if (tpq_pkg::entry_before(cur_r, rd)) begin
          wdata = rd; idx_nxt = pidx; state_nxt = S_SU;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SD: begin
        if (lidx >= (CW + 1)'(cnt_r)) begin
          we = 1'b1; state_nxt = sd_done;
        end else begin
          raddr = lidx[AW-1:0]; state_nxt = S_SD_R;
        end
      end
      S_SD_R: begin
        lch_nxt = rd;
        rv_nxt = ridx < (CW + 1)'(cnt_r);
        raddr = ridx[AW-1:0];
        state_nxt = S_SD_CMP;
      end
      S_SD_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata = rd; idx_nxt = ridx[AW-1:0]; state_nxt = S_SD;
        end else if (take_l) begin
          wdata = lch_r; idx_nxt = lidx[AW-1:0]; state_nxt = S_SD;
        end else begin
          state_nxt = sd_done;
        end
      end
      S_POP: begin
        cnt_nxt = cnt_r - CW'(1);
        raddr = AW'(cnt_r - CW'(1));
        state_nxt = (cnt_r == CW'(1)) ? sd_done : S_POP_W;
      end
      S_POP_W: begin
        cur_nxt = rd; idx_nxt = '0; state_nxt = S_SD;
      end
      S_CN_RD: state_nxt = S_CN_CHK;
      S_CN_CHK: begin
        if (!rd.canc && rd.id == tid_r) begin
          we = 1'b1; wdata = rd; wdata.canc = 1'b1;
          efound_nxt = 1'b1; state_nxt = S_CN_POP;
        end else if (idx_inc == cnt_r) begin
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_inc[AW-1:0]; state_nxt = S_CN_RD;
        end
      end
      S_CN_POP: state_nxt = (cnt_r != '0 && top_r.canc) ? S_POP : S_EMIT;
      S_PR_CHK: begin
        pend_nxt = 1'b0;
        if (cnt_r != '0 && top_r.fire <= tv_r) begin
          if (top_r.canc) begin
            state_nxt = S_POP;
          end else if (fires_r >= 6'(MAX_FIRES)) begin
            more_nxt = 1'b1; ekind_nxt = tpq_pkg::KIND_DONE; ehandle_nxt = '0;
            state_nxt = S_EMIT;
          end else begin
            ehandle_nxt = top_r.id; fires_nxt = fires_r + 6'd1;
            ekind_nxt = tpq_pkg::KIND_FIRE; pend_nxt = 1'b1;
            if (top_r.ival != '0) begin
              cur_nxt = top_r;
              cur_nxt.fire = sat_sum[32] ? '1 : sat_sum[31:0];
              idx_nxt = '0; state_nxt = S_SD;
            end else begin
              state_nxt = S_POP;
            end
          end
        end else begin
          ekind_nxt = tpq_pkg::KIND_DONE; ehandle_nxt = '0; state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) state_nxt = (ekind_r == tpq_pkg::KIND_FIRE) ? S_PR_CHK : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    emit.valid        = (state_r == S_EMIT);
    emit.kind         = ekind_r;
    emit.handle       = ehandle_r;
    emit.found        = efound_r;
    emit.fired_count  = (ekind_r == tpq_pkg::KIND_DONE) ? fires_r : 6'd0;
    emit.more_pending = (ekind_r == tpq_pkg::KIND_DONE) && more_r;
    emit.occupancy    = 5'(cnt_r);
    if (cnt_r == '0 || top_r.canc) emit.next_delay = '1;
    else if (top_r.fire > tv_r) emit.next_delay = top_r.fire - tv_r;
    else emit.next_delay = '0;
    emit.last         = (ekind_r != tpq_pkg::KIND_FIRE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      hnd_r   <= '0;
      fires_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      hnd_r   <= hnd_nxt;
      fires_r <= fires_nxt;
    end
    op_r <= op_nxt; tv_r <= tv_nxt; tid_r <= tid_nxt; idx_r <= idx_nxt;
    cur_r <= cur_nxt; lch_r <= lch_nxt; rv_r <= rv_nxt;
    more_r <= more_nxt; pend_r <= pend_nxt; ekind_r <= ekind_nxt;
    ehandle_r <= ehandle_nxt; efound_r <= efound_nxt;
    if (we && waddr == '0) top_r <= wdata;
  end

`ifndef NO_ASSERTIONS
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY)) else $error("occupancy beyond capacity");
  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fires_r <= 6'(MAX_FIRES)) else $error("fire count beyond cap");
  a_idle_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !we) else $error("ram write while idle");
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != S_IDLE) else $error("request dropped");
`endif

endmodule

// ===== test/tb_pkg.sv =====
// scoreboard class and result record for the timer queue testbench
package tb_pkg;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] handle;
    logic        found;
    logic [5:0]  fired_count;
    logic        more_pending;
    logic [4:0]  occupancy;
    logic [31:0] next_delay;
    logic        last;
  } result_t;

  localparam int CAP = 16;
  localparam int FIRE_CAP = 63;

  class timer_scoreboard;
    logic [31:0] fire_t [CAP];
    logic [31:0] ival_t [CAP];
    logic [31:0] id_t [CAP];
    logic        canc_t [CAP];
    int unsigned count;
    logic [31:0] next_id;
    result_t     pending[$];
    int          errors;
    int          checked;
    int          fires_seen;

    function void clear();
      count = 0;
      next_id = 0;
      pending.delete();
      errors = 0;
      checked = 0;
      fires_seen = 0;
    endfunction

    function bit earlier(int a, int b);
      if (fire_t[a] != fire_t[b]) return fire_t[a] < fire_t[b];
      return id_t[a] < id_t[b];
    endfunction

    function void swap(int a, int b);
      logic [31:0] t;
      logic c;
      t = fire_t[a]; fire_t[a] = fire_t[b]; fire_t[b] = t;
      t = ival_t[a]; ival_t[a] = ival_t[b]; ival_t[b] = t;
      t = id_t[a]; id_t[a] = id_t[b]; id_t[b] = t;
      c = canc_t[a]; canc_t[a] = canc_t[b]; canc_t[b] = c;
    endfunction

    function void rise(int i);
      int p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!earlier(i, p)) break;
        swap(i, p);
        i = p;
      end
    endfunction

    function void sink_down(int i);
      int l, r, m;
      forever begin
        l = 2 * i + 1;
        r = l + 1;
        m = i;
        if (l < count && earlier(l, m)) m = l;
        if (r < count && earlier(r, m)) m = r;
        if (m == i) break;
        swap(i, m);
        i = m;
      end
    endfunction

    function void drop_top();
      count--;
      if (count > 0) begin
        swap(0, count);
        sink_down(0);
      end
    endfunction

    function logic [31:0] delay_at(logic [31:0] now);
      if (count == 0 || canc_t[0]) return '1;
      return fire_t[0] > now ? fire_t[0] - now : 32'd0;
    endfunction

    function void push(logic [2:0] kind, logic [31:0] h, logic f, logic [5:0] n,
                       logic m, logic [31:0] now, logic l);
      result_t r;
      r.kind = kind;
      r.handle = h;
      r.found = f;
      r.fired_count = n;
      r.more_pending = m;
      r.occupancy = count[4:0];
      r.next_delay = delay_at(now);
      r.last = l;
      pending = {pending, r};
    endfunction

    function void note_request(logic [1:0] act, logic [31:0] tv, logic [31:0] iv,
                               logic [31:0] tid);
      int i;
      bit hit;
      int fires;
      bit more;
      logic [31:0] id, s;
      case (act)
        tpq_pkg::ACT_SCHED: begin
          if (count >= CAP) begin
            push(tpq_pkg::KIND_FULL, 0, 0, 0, 0, tv, 1);
          end else begin
            id = next_id;
            next_id++;
            i = count;
            count++;
            fire_t[i] = tv; ival_t[i] = iv; id_t[i] = id; canc_t[i] = 0;
            rise(i);
            push(tpq_pkg::KIND_GRANT, id, 0, 0, 0, tv, 1);
          end
        end
        tpq_pkg::ACT_CANCEL: begin
          hit = 0;
          for (i = 0; i < count; i++) begin
            if (!canc_t[i] && id_t[i] == tid) begin
              canc_t[i] = 1;
              hit = 1;
              break;
            end
          end
          if (hit) while (count > 0 && canc_t[0]) drop_top();
          push(tpq_pkg::KIND_CANCEL, 0, hit, 0, 0, tv, 1);
        end
        tpq_pkg::ACT_PROCESS: begin
          fires = 0;
          more = 0;
          while (count > 0 && fire_t[0] <= tv) begin
            id = id_t[0];
            if (canc_t[0]) begin
              drop_top();
              continue;
            end
            if (fires >= FIRE_CAP) begin
              more = 1;
              break;
            end
            if (ival_t[0] != 0) begin
              s = fire_t[0] + ival_t[0];
              fire_t[0] = (s < fire_t[0]) ? '1 : s;
              sink_down(0);
            end else begin
              drop_top();
            end
            fires++;
            push(tpq_pkg::KIND_FIRE, id, 0, 0, 0, tv, 0);
          end
          push(tpq_pkg::KIND_DONE, 0, 0, fires[5:0], more, tv, 1);
        end
        default: push(tpq_pkg::KIND_DONE, 0, 0, 0, 0, tv, 1);
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (got.kind == tpq_pkg::KIND_FIRE) fires_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass
endpackage

// ===== test/testbench.sv =====
// top level testbench of the timer priority queue: directed and random requests
module testbench;

  logic clk = 0;
  logic rst_n = 0;
  longint cycles = 0;
  logic stall_mode = 0;
  tb_pkg::timer_scoreboard sb;
  logic [31:0] base_time = 0;
  logic [31:0] issued[$];

  tpq_in_if  in_ch ();
  tpq_out_if out_ch ();

  timer_priority_queue_top u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.action = 0;
    in_ch.time_value = 0;
    in_ch.repeat_interval = 0;
    in_ch.timer_id = 0;
    out_ch.ready = 0;
  end

  // receiver stalls in its own pattern, switching between bursty and free
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst_n) out_ch.ready <= 0;
    else if (stall_mode) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= ($urandom_range(0, 9) != 0) || (cycles[6:5] == 2'b01);
    if ((cycles & 511) == 0) stall_mode <= 1'($urandom_range(0, 1));
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.kind, out_ch.handle, out_ch.found, out_ch.fired_count,
                       out_ch.more_pending, out_ch.occupancy, out_ch.next_delay,
                       out_ch.last});
  end

  task automatic send(logic [1:0] act, logic [31:0] tv, logic [31:0] iv, logic [31:0] tid);
    in_ch.valid <= 1;
    in_ch.action <= act;
    in_ch.time_value <= tv;
    in_ch.repeat_interval <= iv;
    in_ch.timer_id <= tid;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(act, tv, iv, tid);
    if (act == tpq_pkg::ACT_SCHED && sb.pending.size() > 0 &&
        sb.pending[$].kind == tpq_pkg::KIND_GRANT)
      issued = {issued, sb.pending[$].handle};
  endtask

  task automatic gap();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    if (n > 0) begin
      in_ch.valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    do @(posedge clk); while (sb.pending.size() > 0);
  endtask

  function automatic logic [31:0] pick_id();
    if (issued.size() > 0 && $urandom_range(0, 4) != 0)
      return issued[$urandom_range(0, issued.size() - 1)];
    return $urandom;
  endfunction

  task automatic random_request();
    int r;
    logic [31:0] iv;
    r = $urandom_range(0, 99);
    iv = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 200);
    if ($urandom_range(0, 30) == 0) iv = $urandom;
    if (r < 45)
      send(tpq_pkg::ACT_SCHED, base_time + $urandom_range(0, 300), iv, 0);
    else if (r < 62)
      send(tpq_pkg::ACT_CANCEL, base_time + $urandom_range(0, 50), 0, pick_id());
    else if (r < 95) begin
      base_time = base_time + $urandom_range(0, 120);
      send(tpq_pkg::ACT_PROCESS, base_time, $urandom, $urandom);
    end else if (r < 97)
      send(2'd3, $urandom, $urandom, $urandom);
    else
      send(tpq_pkg::ACT_SCHED, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int i, burst;
    sb = new();
    sb.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, duplicates, full heap, cap, saturation, unknown action
    send(tpq_pkg::ACT_PROCESS, 0, 0, 0);
    send(tpq_pkg::ACT_CANCEL, 5, 0, 32'hFFFF_FFFF);
    send(tpq_pkg::ACT_SCHED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(tpq_pkg::ACT_SCHED, 10, 0, 0);
    send(tpq_pkg::ACT_SCHED, 10, 5, 0);
    send(tpq_pkg::ACT_SCHED, 32'hFFFF_FFF0, 32'h8000_0000, 0);
    send(tpq_pkg::ACT_CANCEL, 0, 0, 1);
    send(tpq_pkg::ACT_CANCEL, 0, 0, 1);
    send(tpq_pkg::ACT_PROCESS, 12, 0, 0);
    send(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (i = 0; i < 14; i++) send(tpq_pkg::ACT_SCHED, 20, 1, 0);
    send(tpq_pkg::ACT_SCHED, 0, 0, 0);
    send(tpq_pkg::ACT_PROCESS, 32'hFFFF_FFFE, 0, 0);
    send(tpq_pkg::ACT_PROCESS, 32'hFFFF_FFFF, 0, 0);
    drain();
    // clear out the saturated repeating timers
    for (i = 0; i < 20; i++) send(tpq_pkg::ACT_CANCEL, 0, 0, i);
    drain();

    base_time = 1000;
    for (i = 0; i < 330; ) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && i < 330) begin
        random_request();
        burst--;
        i++;
      end
      gap();
      if (i == 160) drain();
    end
    drain();
    repeat (200) @(posedge clk);

    $display("ran %0d results, %0d fires, heap filled and id wrap-free random traffic",
             sb.checked, sb.fires_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d left over", sb.errors, sb.pending.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule
